// ===== design/vcrf_pkg.sv =====
// Shared constants, register map and command codes for the video chip register file.
package vcrf_pkg;

    localparam int NUM_SPRITES = 8;
    localparam int NUM_COLORS  = 15;
    localparam int SPR_IDX_W   = $clog2(NUM_SPRITES);
    localparam int COLOR_IDX_W = $clog2(NUM_COLORS);

    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 8;
    localparam int LINE_W  = 9;
    localparam int IRQ_W   = 4;
    localparam int MODE_W  = 3;
    localparam int SCROLL_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_IRQ   = 2'd2
    } cmd_t;

    localparam logic [ADDR_W-1:0] ADDR_SPR_X_MSB  = 6'h10;
    localparam logic [ADDR_W-1:0] ADDR_CTRL_ONE   = 6'h11;
    localparam logic [ADDR_W-1:0] ADDR_RASTER     = 6'h12;
    localparam logic [ADDR_W-1:0] ADDR_PEN_X      = 6'h13;
    localparam logic [ADDR_W-1:0] ADDR_PEN_Y      = 6'h14;
    localparam logic [ADDR_W-1:0] ADDR_SPR_EN     = 6'h15;
    localparam logic [ADDR_W-1:0] ADDR_CTRL_TWO   = 6'h16;
    localparam logic [ADDR_W-1:0] ADDR_SPR_YEXP   = 6'h17;
    localparam logic [ADDR_W-1:0] ADDR_MEM_PTR    = 6'h18;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_REQ    = 6'h19;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_MASK   = 6'h1A;
    localparam logic [ADDR_W-1:0] ADDR_SPR_PRIO   = 6'h1B;
    localparam logic [ADDR_W-1:0] ADDR_SPR_MCOL   = 6'h1C;
    localparam logic [ADDR_W-1:0] ADDR_SPR_XEXP   = 6'h1D;
    localparam logic [ADDR_W-1:0] ADDR_COLL_SS    = 6'h1E;
    localparam logic [ADDR_W-1:0] ADDR_COLL_SB    = 6'h1F;
    localparam logic [ADDR_W-1:0] ADDR_COLOR_BASE = 6'h20;

    localparam logic [DATA_W-1:0] FILL_COLOR    = 8'hF0;
    localparam logic [DATA_W-1:0] FILL_IRQ_OFF  = 8'h70;
    localparam logic [DATA_W-1:0] FILL_IRQ_ON   = 8'hF0;
    localparam logic [DATA_W-1:0] FILL_CTRL_TWO = 8'hC0;
    localparam logic [DATA_W-1:0] FILL_MEM_PTR  = 8'h01;
    localparam logic [DATA_W-1:0] FILL_MASK     = 8'hF0;
    localparam logic [DATA_W-1:0] FILL_UNUSED   = 8'hFF;

endpackage

// ===== design/video_chip_register_file.sv =====
// Video chip register file: bus access decode, register state and derived display values.
// Each beat passes the input register, one combinational pass and the result register.
// Throughput: one beat per cycle while rsp_stall does not hold the result; register state
// updates as the result is loaded.
// Reset: all register state, the gray dot setting and both valid flags clear to zero.
module video_chip_register_file (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_enable,
    input  logic                                cfg_write_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [vcrf_pkg::CMD_W-1:0]          cmd,
    input  logic [vcrf_pkg::ADDR_W-1:0]         reg_addr,
    input  logic [vcrf_pkg::DATA_W-1:0]         write_data,
    input  logic [vcrf_pkg::LINE_W-1:0]         raster_line,
    input  logic [vcrf_pkg::DATA_W-1:0]         pen_x,
    input  logic [vcrf_pkg::DATA_W-1:0]         pen_y,
    input  logic [vcrf_pkg::NUM_SPRITES-1:0]    sprite_sprite_hits,
    input  logic [vcrf_pkg::NUM_SPRITES-1:0]    sprite_bg_hits,
    input  logic [vcrf_pkg::IRQ_W-1:0]          irq_sources,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [vcrf_pkg::DATA_W-1:0]         read_data,
    output logic                                irq_active,
    output logic                                clear_sprite_sprite,
    output logic                                clear_sprite_bg,
    output logic [vcrf_pkg::LINE_W-1:0]         raster_compare,
    output logic [vcrf_pkg::MODE_W-1:0]         display_mode,
    output logic [vcrf_pkg::SCROLL_W-1:0]       x_scroll,
    output logic                                gray_dot,
    output logic [vcrf_pkg::NUM_SPRITES-1:0]    expand_flops,
    output logic [vcrf_pkg::NUM_SPRITES-1:0]    expand_cleared,
    output logic                                regs_update
);
    import vcrf_pkg::*;

    // input register
    logic                   in_valid_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [DATA_W-1:0]      wdata_reg;
    logic [LINE_W-1:0]      line_reg;
    logic [DATA_W-1:0]      pen_x_reg;
    logic [DATA_W-1:0]      pen_y_reg;
    logic [NUM_SPRITES-1:0] hits_ss_reg;
    logic [NUM_SPRITES-1:0] hits_sb_reg;
    logic [IRQ_W-1:0]       irq_src_reg;

    // result register
    logic                   out_valid_reg;
    logic [DATA_W-1:0]      read_data_reg;
    logic                   irq_active_reg;
    logic                   clr_ss_reg;
    logic                   clr_sb_reg;
    logic [LINE_W-1:0]      raster_cmp_out_reg;
    logic [MODE_W-1:0]      mode_reg;
    logic [SCROLL_W-1:0]    scroll_reg;
    logic                   gray_reg;
    logic [NUM_SPRITES-1:0] flops_out_reg;
    logic [NUM_SPRITES-1:0] cleared_reg;
    logic                   update_reg;

    // register file state
    logic                   gray_dot_bug_reg;
    logic [DATA_W-1:0]      xpos_lo_reg [NUM_SPRITES];
    logic [DATA_W-1:0]      xpos_lo_next [NUM_SPRITES];
    logic [NUM_SPRITES-1:0] xpos_msb_reg;
    logic [NUM_SPRITES-1:0] xpos_msb_next;
    logic [DATA_W-1:0]      ypos_reg [NUM_SPRITES];
    logic [DATA_W-1:0]      ypos_next [NUM_SPRITES];
    logic [3:0]             color_reg [NUM_COLORS];
    logic [3:0]             color_next [NUM_COLORS];
    logic [DATA_W-1:0]      ctrl_one_reg, ctrl_one_next;
    logic [DATA_W-1:0]      ctrl_two_reg, ctrl_two_next;
    logic [DATA_W-1:0]      spr_en_reg, spr_en_next;
    logic [DATA_W-1:0]      spr_yexp_reg, spr_yexp_next;
    logic [DATA_W-1:0]      spr_xexp_reg, spr_xexp_next;
    logic [DATA_W-1:0]      spr_prio_reg, spr_prio_next;
    logic [DATA_W-1:0]      spr_mcol_reg, spr_mcol_next;
    logic [DATA_W-1:0]      mem_ptr_reg, mem_ptr_next;
    logic [IRQ_W-1:0]       irq_req_reg, irq_req_next;
    logic [IRQ_W-1:0]       irq_mask_reg, irq_mask_next;
    logic [LINE_W-1:0]      raster_cmp_reg, raster_cmp_next;
    logic [NUM_SPRITES-1:0] yexp_flops_reg, yexp_flops_next;

    // combinational results
    logic                   advance;
    logic [SPR_IDX_W-1:0]   spr_idx;
    logic [COLOR_IDX_W-1:0] color_idx;
    logic                   is_sprite_pos;
    logic                   is_color;
    logic                   irq_now;
    logic [DATA_W-1:0]      rd_value;
    logic [DATA_W-1:0]      rd_data;
    logic                   clr_ss;
    logic                   clr_sb;
    logic                   gray;
    logic [NUM_SPRITES-1:0] cleared;
    logic                   upd;

    assign advance   = !out_valid_reg || !rsp_stall;
    assign req_stall = in_valid_reg && !advance;

    assign spr_idx       = addr_reg[SPR_IDX_W:1];
    assign color_idx     = addr_reg[COLOR_IDX_W-1:0];
    assign is_sprite_pos = (addr_reg[ADDR_W-1:4] == 2'b00);
    assign is_color      = (addr_reg[ADDR_W-1:4] == ADDR_COLOR_BASE[ADDR_W-1:4])
                           && (color_idx != COLOR_IDX_W'(NUM_COLORS));
    assign irq_now       = |(irq_req_reg & irq_mask_reg);

    // read mux on current state
    always_comb
    begin
        rd_value = FILL_UNUSED;
        priority if (is_sprite_pos)
        begin
            rd_value = addr_reg[0] ? ypos_reg[spr_idx] : xpos_lo_reg[spr_idx];
        end
        else if (is_color)
        begin
            rd_value = {4'h0, color_reg[color_idx]} | FILL_COLOR;
        end
        else
        begin
            case (addr_reg)
                ADDR_SPR_X_MSB: rd_value = xpos_msb_reg;
                ADDR_CTRL_ONE:  rd_value = {line_reg[LINE_W-1], ctrl_one_reg[6:0]};
                ADDR_RASTER:    rd_value = line_reg[DATA_W-1:0];
                ADDR_PEN_X:     rd_value = pen_x_reg;
                ADDR_PEN_Y:     rd_value = pen_y_reg;
                ADDR_SPR_EN:    rd_value = spr_en_reg;
                ADDR_CTRL_TWO:  rd_value = ctrl_two_reg | FILL_CTRL_TWO;
                ADDR_SPR_YEXP:  rd_value = spr_yexp_reg;
                ADDR_MEM_PTR:   rd_value = mem_ptr_reg | FILL_MEM_PTR;
                ADDR_IRQ_REQ:   rd_value = {4'h0, irq_req_reg}
                                           | (irq_now ? FILL_IRQ_ON : FILL_IRQ_OFF);
                ADDR_IRQ_MASK:  rd_value = {4'h0, irq_mask_reg} | FILL_MASK;
                ADDR_SPR_PRIO:  rd_value = spr_prio_reg;
                ADDR_SPR_MCOL:  rd_value = spr_mcol_reg;
                ADDR_SPR_XEXP:  rd_value = spr_xexp_reg;
                ADDR_COLL_SS:   rd_value = hits_ss_reg;
                ADDR_COLL_SB:   rd_value = hits_sb_reg;
                default:        rd_value = FILL_UNUSED;
            endcase
        end
    end

    // state update and result fields
    always_comb
    begin
        xpos_lo_next    = xpos_lo_reg;
        xpos_msb_next   = xpos_msb_reg;
        ypos_next       = ypos_reg;
        color_next      = color_reg;
        ctrl_one_next   = ctrl_one_reg;
        ctrl_two_next   = ctrl_two_reg;
        spr_en_next     = spr_en_reg;
        spr_yexp_next   = spr_yexp_reg;
        spr_xexp_next   = spr_xexp_reg;
        spr_prio_next   = spr_prio_reg;
        spr_mcol_next   = spr_mcol_reg;
        mem_ptr_next    = mem_ptr_reg;
        irq_req_next    = irq_req_reg;
        irq_mask_next   = irq_mask_reg;
        raster_cmp_next = raster_cmp_reg;
        yexp_flops_next = yexp_flops_reg;
        rd_data = '0;
        clr_ss  = 1'b0;
        clr_sb  = 1'b0;
        gray    = 1'b0;
        cleared = '0;
        upd     = 1'b0;
        case (cmd_reg)
            CMD_READ:
            begin
                rd_data = rd_value;
                clr_ss  = (addr_reg == ADDR_COLL_SS);
                clr_sb  = (addr_reg == ADDR_COLL_SB);
            end
            CMD_WRITE:
            begin
                upd = 1'b1;
                priority if (is_sprite_pos)
                begin
                    if (addr_reg[0])
                        ypos_next[spr_idx] = wdata_reg;
                    else
                        xpos_lo_next[spr_idx] = wdata_reg;
                end
                else if (is_color)
                begin
                    color_next[color_idx] = wdata_reg[3:0];
                    gray = gray_dot_bug_reg;
                end
                else
                begin
                    case (addr_reg)
                        ADDR_SPR_X_MSB: xpos_msb_next = wdata_reg;
                        ADDR_CTRL_ONE:
                        begin
                            ctrl_one_next = wdata_reg;
                            raster_cmp_next[LINE_W-1] = wdata_reg[DATA_W-1];
                        end
                        ADDR_RASTER:
                        begin
                            raster_cmp_next[DATA_W-1:0] = wdata_reg;
                            upd = 1'b0;
                        end
                        ADDR_SPR_EN:   spr_en_next = wdata_reg;
                        ADDR_CTRL_TWO: ctrl_two_next = wdata_reg;
                        ADDR_SPR_YEXP:
                        begin
                            spr_yexp_next   = wdata_reg;
                            cleared         = ~wdata_reg & ~yexp_flops_reg;
                            yexp_flops_next = yexp_flops_reg | ~wdata_reg;
                        end
                        ADDR_MEM_PTR:
                        begin
                            mem_ptr_next = wdata_reg;
                            upd = 1'b0;
                        end
                        ADDR_IRQ_REQ:
                        begin
                            irq_req_next = irq_req_reg & ~wdata_reg[IRQ_W-1:0];
                            upd = 1'b0;
                        end
                        ADDR_IRQ_MASK:
                        begin
                            irq_mask_next = wdata_reg[IRQ_W-1:0];
                            upd = 1'b0;
                        end
                        ADDR_SPR_PRIO: spr_prio_next = wdata_reg;
                        ADDR_SPR_MCOL: spr_mcol_next = wdata_reg;
                        ADDR_SPR_XEXP: spr_xexp_next = wdata_reg;
                        ADDR_PEN_X, ADDR_PEN_Y, ADDR_COLL_SS, ADDR_COLL_SB: upd = 1'b0;
                        default: ;
                    endcase
                end
            end
            CMD_IRQ: irq_req_next = irq_req_reg | irq_src_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gray_dot_bug_reg <= 1'b0;
        else if (cfg_write_enable)
            gray_dot_bug_reg <= cfg_write_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!req_stall)
                in_valid_reg <= req_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            cmd_reg     <= cmd;
            addr_reg    <= reg_addr;
            wdata_reg   <= write_data;
            line_reg    <= raster_line;
            pen_x_reg   <= pen_x;
            pen_y_reg   <= pen_y;
            hits_ss_reg <= sprite_sprite_hits;
            hits_sb_reg <= sprite_bg_hits;
            irq_src_reg <= irq_sources;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            read_data_reg      <= rd_data;
            irq_active_reg     <= |(irq_req_next & irq_mask_next);
            clr_ss_reg         <= clr_ss;
            clr_sb_reg         <= clr_sb;
            raster_cmp_out_reg <= raster_cmp_next;
            mode_reg           <= {ctrl_one_next[6:5], ctrl_two_next[4]};
            scroll_reg         <= ctrl_two_next[SCROLL_W-1:0];
            gray_reg           <= gray;
            flops_out_reg      <= yexp_flops_next;
            cleared_reg        <= cleared;
            update_reg         <= upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SPRITES; i++)
            begin
                xpos_lo_reg[i] <= '0;
                ypos_reg[i]    <= '0;
            end
            for (int i = 0; i < NUM_COLORS; i++)
                color_reg[i] <= '0;
            xpos_msb_reg   <= '0;
            ctrl_one_reg   <= '0;
            ctrl_two_reg   <= '0;
            spr_en_reg     <= '0;
            spr_yexp_reg   <= '0;
            spr_xexp_reg   <= '0;
            spr_prio_reg   <= '0;
            spr_mcol_reg   <= '0;
            mem_ptr_reg    <= '0;
            irq_req_reg    <= '0;
            irq_mask_reg   <= '0;
            raster_cmp_reg <= '0;
            yexp_flops_reg <= '0;
        end
        else if (advance && in_valid_reg)
        begin
            xpos_lo_reg    <= xpos_lo_next;
            ypos_reg       <= ypos_next;
            color_reg      <= color_next;
            xpos_msb_reg   <= xpos_msb_next;
            ctrl_one_reg   <= ctrl_one_next;
            ctrl_two_reg   <= ctrl_two_next;
            spr_en_reg     <= spr_en_next;
            spr_yexp_reg   <= spr_yexp_next;
            spr_xexp_reg   <= spr_xexp_next;
            spr_prio_reg   <= spr_prio_next;
            spr_mcol_reg   <= spr_mcol_next;
            mem_ptr_reg    <= mem_ptr_next;
            irq_req_reg    <= irq_req_next;
            irq_mask_reg   <= irq_mask_next;
            raster_cmp_reg <= raster_cmp_next;
            yexp_flops_reg <= yexp_flops_next;
        end
    end

    assign rsp_valid           = out_valid_reg;
    assign read_data           = read_data_reg;
    assign irq_active          = irq_active_reg;
    assign clear_sprite_sprite = clr_ss_reg;
    assign clear_sprite_bg     = clr_sb_reg;
    assign raster_compare      = raster_cmp_out_reg;
    assign display_mode        = mode_reg;
    assign x_scroll            = scroll_reg;
    assign gray_dot            = gray_reg;
    assign expand_flops        = flops_out_reg;
    assign expand_cleared      = cleared_reg;
    assign regs_update         = update_reg;

    // state and pending result stay in step
    a_irq_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (irq_active == irq_now))
        else $error("irq_active out of step with request and mask state");

    a_state_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (raster_compare == raster_cmp_reg) && (expand_flops == yexp_flops_reg))
        else $error("result fields out of step with register state");

    a_cleared_bits_set: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((expand_cleared & ~expand_flops) == '0))
        else $error("cleared expand bit not set in flops");

    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> $stable(irq_req_reg) && $stable(raster_cmp_reg))
        else $error("register state moved while result beat stalled");

    a_collision_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(clear_sprite_sprite && clear_sprite_bg))
        else $error("both collision clears raised by one beat");

endmodule

// ===== tb/tb_video_chip_register_file.sv =====
`timescale 1ns / 1ps
// Testbench for the video chip register file: directed register table, then random bus beats.
module tb_video_chip_register_file;
    import vcrf_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNDEF       = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_SPR0_X     = 6'h00;
    localparam logic [ADDR_W-1:0] ADDR_SPR7_X     = 6'h0E;
    localparam logic [ADDR_W-1:0] ADDR_UNUSED_LO  = ADDR_COLOR_BASE + ADDR_W'(NUM_COLORS);
    localparam logic [ADDR_W-1:0] ADDR_COLOR_LAST = ADDR_COLOR_BASE + ADDR_W'(NUM_COLORS - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST       = 6'h3F;
    localparam int IDLE_PCT       = 38;
    localparam int RAND_PER_PHASE = 125;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic [ADDR_W-1:0]      addr;
        logic [DATA_W-1:0]      wdata;
        logic [LINE_W-1:0]      line;
        logic [DATA_W-1:0]      pen_x;
        logic [DATA_W-1:0]      pen_y;
        logic [NUM_SPRITES-1:0] ss_hits;
        logic [NUM_SPRITES-1:0] sb_hits;
        logic [IRQ_W-1:0]       irq_src;
    } bus_access_t;

    typedef struct packed {
        logic [DATA_W-1:0]      rdata;
        logic                   irq;
        logic                   clr_ss;
        logic                   clr_sb;
        logic [LINE_W-1:0]      cmp;
        logic [MODE_W-1:0]      mode;
        logic [SCROLL_W-1:0]    xscroll;
        logic                   gray;
        logic [NUM_SPRITES-1:0] flops;
        logic [NUM_SPRITES-1:0] cleared;
        logic                   upd;
    } bus_result_t;

    typedef struct {
        bus_access_t       acc;
        bit                fixed;
        logic [DATA_W-1:0] rdata;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_enable = 1'b0;
    logic                   cfg_write_data = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic [CMD_W-1:0]       cmd = CMD_READ;
    logic [ADDR_W-1:0]      reg_addr = '0;
    logic [DATA_W-1:0]      write_data = '0;
    logic [LINE_W-1:0]      raster_line = '0;
    logic [DATA_W-1:0]      pen_x = '0;
    logic [DATA_W-1:0]      pen_y = '0;
    logic [NUM_SPRITES-1:0] sprite_sprite_hits = '0;
    logic [NUM_SPRITES-1:0] sprite_bg_hits = '0;
    logic [IRQ_W-1:0]       irq_sources = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    logic [DATA_W-1:0]      read_data;
    logic                   irq_active;
    logic                   clear_sprite_sprite;
    logic                   clear_sprite_bg;
    logic [LINE_W-1:0]      raster_compare;
    logic [MODE_W-1:0]      display_mode;
    logic [SCROLL_W-1:0]    x_scroll;
    logic                   gray_dot;
    logic [NUM_SPRITES-1:0] expand_flops;
    logic [NUM_SPRITES-1:0] expand_cleared;
    logic                   regs_update;

    video_chip_register_file dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write_enable    (cfg_write_enable),
        .cfg_write_data      (cfg_write_data),
        .req_valid           (req_valid),
        .req_stall           (req_stall),
        .cmd                 (cmd),
        .reg_addr            (reg_addr),
        .write_data          (write_data),
        .raster_line         (raster_line),
        .pen_x               (pen_x),
        .pen_y               (pen_y),
        .sprite_sprite_hits  (sprite_sprite_hits),
        .sprite_bg_hits      (sprite_bg_hits),
        .irq_sources         (irq_sources),
        .rsp_valid           (rsp_valid),
        .rsp_stall           (rsp_stall),
        .read_data           (read_data),
        .irq_active          (irq_active),
        .clear_sprite_sprite (clear_sprite_sprite),
        .clear_sprite_bg     (clear_sprite_bg),
        .raster_compare      (raster_compare),
        .display_mode        (display_mode),
        .x_scroll            (x_scroll),
        .gray_dot            (gray_dot),
        .expand_flops        (expand_flops),
        .expand_cleared      (expand_cleared),
        .regs_update         (regs_update)
    );

    // register file image
    logic [LINE_W-1:0]      m_xpos [NUM_SPRITES];
    logic [DATA_W-1:0]      m_ypos [NUM_SPRITES];
    logic [3:0]             m_color [NUM_COLORS];
    logic [DATA_W-1:0]      m_ctrl1, m_ctrl2, m_spr_en, m_yexp, m_xexp;
    logic [DATA_W-1:0]      m_prio, m_mcol, m_mem_ptr;
    logic [IRQ_W-1:0]       m_irq_req, m_irq_mask;
    logic [LINE_W-1:0]      m_cmp_line;
    logic [NUM_SPRITES-1:0] m_yexp_ff;
    logic                   m_gray_bug;

    bus_result_t results_due [$];
    dir_row_t    dir_rows [$];
    bus_result_t seen_rsp, due_rsp;
    int          mismatch_cnt = 0;
    bit          calm = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
        rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

    function automatic logic [DATA_W-1:0] read_byte(input bus_access_t a);
        logic [DATA_W-1:0] r;
        r = FILL_UNUSED;
        if (a.addr < ADDR_SPR_X_MSB) begin
            if (a.addr[0])
                r = m_ypos[a.addr[3:1]];
            else
                r = m_xpos[a.addr[3:1]][DATA_W-1:0];
        end else if (a.addr >= ADDR_COLOR_BASE && a.addr < ADDR_UNUSED_LO) begin
            r = FILL_COLOR | DATA_W'(m_color[a.addr[COLOR_IDX_W-1:0]]);
        end else begin
            case (a.addr)
                ADDR_SPR_X_MSB: for (int i = 0; i < NUM_SPRITES; i++) r[i] = m_xpos[i][8];
                ADDR_CTRL_ONE:  r = {a.line[8], m_ctrl1[6:0]};
                ADDR_RASTER:    r = a.line[7:0];
                ADDR_PEN_X:     r = a.pen_x;
                ADDR_PEN_Y:     r = a.pen_y;
                ADDR_SPR_EN:    r = m_spr_en;
                ADDR_CTRL_TWO:  r = m_ctrl2 | FILL_CTRL_TWO;
                ADDR_SPR_YEXP:  r = m_yexp;
                ADDR_MEM_PTR:   r = m_mem_ptr | FILL_MEM_PTR;
                ADDR_IRQ_REQ:   r = ((m_irq_req & m_irq_mask) != 0) ?
                                    (FILL_IRQ_ON | DATA_W'(m_irq_req)) :
                                    (FILL_IRQ_OFF | DATA_W'(m_irq_req));
                ADDR_IRQ_MASK:  r = FILL_MASK | DATA_W'(m_irq_mask);
                ADDR_SPR_PRIO:  r = m_prio;
                ADDR_SPR_MCOL:  r = m_mcol;
                ADDR_SPR_XEXP:  r = m_xexp;
                ADDR_COLL_SS:   r = a.ss_hits;
                ADDR_COLL_SB:   r = a.sb_hits;
                default:        r = FILL_UNUSED;
            endcase
        end
        return r;
    endfunction

    task automatic regfile_access(input bus_access_t a, output bus_result_t r);
        logic [DATA_W-1:0] v;
        v = a.wdata;
        r = '0;
        if (a.cmd == CMD_READ) begin
            r.rdata  = read_byte(a);
            r.clr_ss = (a.addr == ADDR_COLL_SS);
            r.clr_sb = (a.addr == ADDR_COLL_SB);
        end else if (a.cmd == CMD_WRITE) begin
            r.upd = 1'b1;
            if (a.addr < ADDR_SPR_X_MSB) begin
                if (a.addr[0])
                    m_ypos[a.addr[3:1]] = v;
                else
                    m_xpos[a.addr[3:1]][DATA_W-1:0] = v;
            end else if (a.addr >= ADDR_COLOR_BASE && a.addr < ADDR_UNUSED_LO) begin
                m_color[a.addr[COLOR_IDX_W-1:0]] = v[3:0];
                r.gray = m_gray_bug;
            end else begin
                case (a.addr)
                    ADDR_SPR_X_MSB: for (int i = 0; i < NUM_SPRITES; i++) m_xpos[i][8] = v[i];
                    ADDR_CTRL_ONE: begin
                        m_ctrl1 = v;
                        m_cmp_line[8] = v[7];
                    end
                    ADDR_RASTER: begin
                        m_cmp_line[7:0] = v;
                        r.upd = 1'b0;
                    end
                    ADDR_SPR_EN:   m_spr_en = v;
                    ADDR_CTRL_TWO: m_ctrl2 = v;
                    ADDR_SPR_YEXP: begin
                        m_yexp = v;
                        r.cleared = ~v & ~m_yexp_ff;
                        m_yexp_ff = m_yexp_ff | ~v;
                    end
                    ADDR_MEM_PTR: begin
                        m_mem_ptr = v;
                        r.upd = 1'b0;
                    end
                    ADDR_IRQ_REQ: begin
                        m_irq_req = m_irq_req & ~v[IRQ_W-1:0];
                        r.upd = 1'b0;
                    end
                    ADDR_IRQ_MASK: begin
                        m_irq_mask = v[IRQ_W-1:0];
                        r.upd = 1'b0;
                    end
                    ADDR_SPR_PRIO: m_prio = v;
                    ADDR_SPR_MCOL: m_mcol = v;
                    ADDR_SPR_XEXP: m_xexp = v;
                    ADDR_PEN_X, ADDR_PEN_Y, ADDR_COLL_SS, ADDR_COLL_SB: r.upd = 1'b0;
                    default: ;
                endcase
            end
        end else if (a.cmd == CMD_IRQ) begin
            m_irq_req = m_irq_req | a.irq_src;
        end
        r.irq     = (m_irq_req & m_irq_mask) != 0;
        r.cmp     = m_cmp_line;
        r.mode    = {m_ctrl1[6:5], m_ctrl2[4]};
        r.xscroll = m_ctrl2[2:0];
        r.flops   = m_yexp_ff;
    endtask

    function automatic dir_row_t dir_row(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] ad,
                                         input logic [DATA_W-1:0] d, input logic [LINE_W-1:0] ln,
                                         input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                                         input logic [DATA_W-1:0] ss, input logic [DATA_W-1:0] sb,
                                         input logic [IRQ_W-1:0] src, input bit fixed,
                                         input logic [DATA_W-1:0] rd);
        dir_row_t row;
        row.acc   = {c, ad, d, ln, px, py, ss, sb, src};
        row.fixed = fixed;
        row.rdata = rd;
        return row;
    endfunction

    function automatic bus_access_t random_access();
        bus_access_t a;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            a.cmd = CMD_READ;
        else if (pick < 80)
            a.cmd = CMD_WRITE;
        else if (pick < 95)
            a.cmd = CMD_IRQ;
        else
            a.cmd = CMD_UNDEF;
        if ($urandom_range(0, 99) < 85)
            a.addr = ADDR_W'($urandom_range(0, ADDR_UNUSED_LO - 1));
        else
            a.addr = ADDR_W'($urandom_range(ADDR_UNUSED_LO, ADDR_LAST));
        a.wdata   = DATA_W'($urandom);
        a.line    = LINE_W'($urandom);
        a.pen_x   = DATA_W'($urandom);
        a.pen_y   = DATA_W'($urandom);
        a.ss_hits = NUM_SPRITES'($urandom);
        a.sb_hits = NUM_SPRITES'($urandom);
        a.irq_src = IRQ_W'($urandom);
        return a;
    endfunction

    function automatic string fmt_result(input bus_result_t r);
        return $sformatf({"rd=%h irq=%b css=%b csb=%b cmp=%h mode=%h xs=%h ",
                          "gray=%b ff=%h clr=%h upd=%b"},
                         r.rdata, r.irq, r.clr_ss, r.clr_sb, r.cmp, r.mode, r.xscroll,
                         r.gray, r.flops, r.cleared, r.upd);
    endfunction

    // entered and left at a rising edge
    task automatic send_beat(input bus_access_t a, input bit fixed, input logic [DATA_W-1:0] rd);
        bus_result_t r;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid          <= 1'b1;
        cmd                <= a.cmd;
        reg_addr           <= a.addr;
        write_data         <= a.wdata;
        raster_line        <= a.line;
        pen_x              <= a.pen_x;
        pen_y              <= a.pen_y;
        sprite_sprite_hits <= a.ss_hits;
        sprite_bg_hits     <= a.sb_hits;
        irq_sources        <= a.irq_src;
        @(negedge clk);
        while (req_stall)
            @(negedge clk);
        regfile_access(a, r);
        if (fixed)
            r.rdata = rd;
        results_due.push_back(r);
        @(posedge clk);
    endtask

    task automatic set_gray_dot(input bit on);
        req_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= on;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        m_gray_bug = on;
    endtask

    always @(negedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall) begin
            seen_rsp = {read_data, irq_active, clear_sprite_sprite, clear_sprite_bg,
                        raster_compare, display_mode, x_scroll, gray_dot, expand_flops,
                        expand_cleared, regs_update};
            if (results_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected beat %s", $realtime, fmt_result(seen_rsp));
            end else begin
                due_rsp = results_due.pop_front();
                if (seen_rsp !== due_rsp) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: mismatch\n  exp %s\n  got %s", $realtime,
                                 fmt_result(due_rsp), fmt_result(seen_rsp));
                end
            end
        end
    end

    initial begin
        #(2_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_SPRITES; i++) begin
            m_xpos[i] = '0;
            m_ypos[i] = '0;
        end
        for (int i = 0; i < NUM_COLORS; i++)
            m_color[i] = '0;
        {m_ctrl1, m_ctrl2, m_spr_en, m_yexp, m_xexp, m_prio, m_mcol, m_mem_ptr} = '0;
        {m_irq_req, m_irq_mask, m_cmp_line, m_yexp_ff, m_gray_bug} = '0;

        // reset values and fill patterns
        dir_rows.push_back(dir_row(CMD_READ, ADDR_SPR0_X, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00));
        dir_rows.push_back(dir_row(CMD_READ, ADDR_CTRL_TWO, 0, 0, 0, 0, 0, 0, 0, 1, 8'hC0));
        dir_rows.push_back(dir_row(CMD_READ, ADDR_IRQ_REQ, 0, 0, 0, 0, 0, 0, 0, 1, 8'h70));
        dir_rows.push_back(dir_row(CMD_READ, ADDR_MEM_PTR, 0, 0, 0, 0, 0, 0, 0, 1, 8'h01));
        dir_rows.push_back(dir_row(CMD_READ, ADDR_COLOR_BASE, 0, 0, 0, 0, 0, 0, 0, 1, 8'hF0));
        dir_rows.push_back(dir_row(CMD_READ, ADDR_LAST, 0, 0, 0, 0, 0, 0, 0, 1, 8'hFF));
        dir_rows.push_back(dir_row(CMD_READ, ADDR_UNUSED_LO, 0, 0, 0, 0, 0, 0, 0, 1, 8'hFF));
        // raster line readback, pen and collision pass-through
        dir_rows.push_back(dir_row(CMD_READ, ADDR_RASTER, 0, 9'h1FF, 0, 0, 0, 0, 0, 1, 8'hFF));
        dir_rows.push_back(dir_row(CMD_READ, ADDR_CTRL_ONE, 0, 9'h1FF, 0, 0, 0, 0, 0, 1, 8'h80));
        dir_rows.push_back(dir_row(CMD_READ, ADDR_PEN_X, 0, 0, 8'hFF, 0, 0, 0, 0, 1, 8'hFF));
        dir_rows.push_back(dir_row(CMD_READ, ADDR_PEN_Y, 0, 0, 0, 8'hA5, 0, 0, 0, 1, 8'hA5));
        dir_rows.push_back(dir_row(CMD_READ, ADDR_COLL_SS, 0, 0, 0, 0, 8'hFF, 0, 0, 1, 8'hFF));
        dir_rows.push_back(dir_row(CMD_READ, ADDR_COLL_SB, 0, 0, 0, 0, 0, 8'h5A, 0, 1, 8'h5A));
        // writes at the extremes
        dir_rows.push_back(dir_row(CMD_WRITE, ADDR_SPR_X_MSB, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_WRITE, ADDR_SPR7_X, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_READ, ADDR_SPR_X_MSB, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_WRITE, ADDR_CTRL_ONE, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_WRITE, ADDR_RASTER, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_WRITE, ADDR_CTRL_TWO, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_WRITE, ADDR_SPR_YEXP, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_WRITE, ADDR_COLOR_LAST, 8'h0F, 0, 0, 0, 0, 0, 0, 0, 0));
        // interrupt raise, status read, write-one-to-clear
        dir_rows.push_back(dir_row(CMD_WRITE, ADDR_IRQ_MASK, 8'h0F, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_IRQ, ADDR_SPR0_X, 0, 0, 0, 0, 0, 0, 4'hF, 0, 0));
        dir_rows.push_back(dir_row(CMD_READ, ADDR_IRQ_REQ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_WRITE, ADDR_IRQ_REQ, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));
        // undefined command, read-only and unused writes
        dir_rows.push_back(dir_row(CMD_UNDEF, ADDR_CTRL_ONE, 8'h00, 0, 0, 0, 0, 0, 4'hF, 0, 0));
        dir_rows.push_back(dir_row(CMD_WRITE, ADDR_PEN_X, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(CMD_WRITE, ADDR_LAST, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_gray_dot(1'b1);
        foreach (dir_rows[i])
            send_beat(dir_rows[i].acc, dir_rows[i].fixed, dir_rows[i].rdata);

        for (int ph = 0; ph < 4; ph++) begin
            set_gray_dot(ph[0]);
            calm = (ph == 2);
            repeat (RAND_PER_PHASE)
                send_beat(random_access(), 1'b0, '0);
        end
        calm = 1'b0;

        req_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
